### design/tcpq_pkg.sv
// ----------------------------------------------------------------------------
// tcpq_pkg: shared types and codes for the two-class priority queue
// Holds the command and status codes, the fixed field widths and the
// result word that travels from the sequencer to the output register.
// ----------------------------------------------------------------------------
package tcpq_pkg;

    localparam int ID_BITS     = 32;
    localparam int STATUS_W    = 2;
    localparam int CMD_W       = 2;
    localparam int REM_W       = 5;
    localparam int SEATS_W     = 4;
    localparam int MAX_BATCH   = 8;

    localparam logic [SEATS_W-1:0] SEATS_RESET = 4'd4;

    localparam logic [CMD_W-1:0] CMD_REGISTER = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CALL     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE   = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_BITS-1:0]  boarded_id;
        logic [REM_W-1:0]    remaining;
        logic                last;
    } out_word_t;

endpackage

### design/tcpq_ram.sv
// ----------------------------------------------------------------------------
// tcpq_ram: queue entry storage
// One write port and one read port; the read data is registered and holds
// its value until the next read.
// ----------------------------------------------------------------------------
module tcpq_ram #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/tcpq_out_reg.sv
// ----------------------------------------------------------------------------
// tcpq_out_reg: result output register
// Holds one result word for the consumer so that the sequencer can go on
// while a finished word waits to be taken.
// ----------------------------------------------------------------------------
module tcpq_out_reg
    import tcpq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  out_word_t load_word,
    output logic      free,
    input  logic      out_ready,
    output logic      out_valid,
    output out_word_t out_word
);

    logic      valid_reg;
    logic      valid_next;
    out_word_t word_reg;

    assign free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= load_word;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

### design/two_class_priority_queue_batch_pop_unit.sv
// ----------------------------------------------------------------------------
// two_class_priority_queue_batch_pop_unit: two-class queue with batch pop
// A circular entry memory walked by a small sequencer, one entry per cycle
// while it moves or searches entries. Fast entries stand before regular
// ones; a counter of fast entries gives the insertion point of a fast entry.
//
//   channel  signals                                  direction
//   input    in_valid in_ready command visitor_id     consumer
//            express
//   output   out_valid out_ready status boarded_id    producer
//            remaining last
//   config   cfg_wr_en cfg_wr_data                    write only
//
// A fast register ahead of regular entries shifts each of them back one
// slot before the new entry is written; a remove searches from the head
// and shifts the entries behind a match forward. A call pops its words
// one by one into the output register. Reset clears occupancy; entries
// need no clearing. Output stalls hold the sequencer only where it must
// load a result word.
// ----------------------------------------------------------------------------
module two_class_priority_queue_batch_pop_unit
    import tcpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_WIDTH    = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [SEATS_W-1:0]  cfg_wr_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [CMD_W-1:0]    command,
    input  logic [ID_BITS-1:0]  visitor_id,
    input  logic                express,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] status,
    output logic [ID_BITS-1:0]  boarded_id,
    output logic [REM_W-1:0]    remaining,
    output logic                last
);

    localparam int STORE_W = (ID_WIDTH < ID_BITS) ? ID_WIDTH : ID_BITS;
    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int MAP_W   = CNT_W + 1;
    localparam int SN_W    = (CNT_W > SEATS_W) ? CNT_W : SEATS_W;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_MOVE   = 6'b000010,
        S_SEARCH = 6'b000100,
        S_POP_RD = 6'b001000,
        S_POP_WR = 6'b010000,
        S_RESULT = 6'b100000
    } state_t;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == '0)
        begin
            r = PTR_W'(QUEUE_DEPTH - 1);
        end
        else
        begin
            r = p - 1'b1;
        end
        return r;
    endfunction

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    occ_reg, occ_next;
    logic [CNT_W-1:0]    fast_cnt_reg, fast_cnt_next;
    logic [PTR_W-1:0]    head_reg, head_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    cmp_ptr_reg, cmp_ptr_next;
    logic [CNT_W-1:0]    rd_left_reg, rd_left_next;
    logic [CNT_W-1:0]    cmp_idx_reg, cmp_idx_next;
    logic [CNT_W-1:0]    pop_left_reg, pop_left_next;
    logic                pend_reg, pend_next;
    logic                insert_reg, insert_next;
    logic [STORE_W-1:0]  id_reg, id_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [SEATS_W-1:0]  seats_reg;

    logic                ram_we;
    logic [PTR_W-1:0]    ram_waddr;
    logic [STORE_W-1:0]  ram_wdata;
    logic                ram_re;
    logic [PTR_W-1:0]    ram_raddr;
    logic [STORE_W-1:0]  ram_rdata;

    logic                out_load;
    logic                out_free;
    out_word_t           load_word;
    out_word_t           out_word;

    logic [MAP_W-1:0]         map_sum;
    logic [PTR_W-1:0]         tail_ptr;
    logic [SEATS_W-1:0]       seats_eff;
    logic [SN_W-1:0]          occ_w;
    logic [SN_W-1:0]          seats_w;
    logic [SN_W-1:0]          pop_w;
    logic [CNT_W-1:0]         pop_n;
    logic [CNT_W-1:0]         fast_pop;
    logic [CNT_W+REM_W-1:0]   occ_ext;
    logic [STORE_W+ID_BITS-1:0] rd_ext;

    // Physical slot just behind the last entry.
    always_comb
    begin
        map_sum = MAP_W'(head_reg) + MAP_W'(occ_reg);
        if (map_sum >= MAP_W'(QUEUE_DEPTH))
        begin
            map_sum = map_sum - MAP_W'(QUEUE_DEPTH);
        end
        tail_ptr = map_sum[PTR_W-1:0];
    end

    always_comb
    begin
        if (seats_reg == '0)
        begin
            seats_eff = SEATS_W'(1);
        end
        else if (seats_reg > SEATS_W'(MAX_BATCH))
        begin
            seats_eff = SEATS_W'(MAX_BATCH);
        end
        else
        begin
            seats_eff = seats_reg;
        end
        occ_w    = SN_W'(occ_reg);
        seats_w  = SN_W'(seats_eff);
        pop_w    = (occ_w < seats_w) ? occ_w : seats_w;
        pop_n    = pop_w[CNT_W-1:0];
        fast_pop = (pop_n < fast_cnt_reg) ? pop_n : fast_cnt_reg;
    end

    assign occ_ext = {{REM_W{1'b0}}, occ_reg};
    assign rd_ext  = {{ID_BITS{1'b0}}, ram_rdata};

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        occ_next        = occ_reg;
        fast_cnt_next   = fast_cnt_reg;
        head_next       = head_reg;
        rd_ptr_next     = rd_ptr_reg;
        wr_ptr_next     = wr_ptr_reg;
        cmp_ptr_next    = cmp_ptr_reg;
        rd_left_next    = rd_left_reg;
        cmp_idx_next    = cmp_idx_reg;
        pop_left_next   = pop_left_reg;
        pend_next       = pend_reg;
        insert_next     = insert_reg;
        id_next         = id_reg;
        res_status_next = res_status_reg;
        ram_we          = 1'b0;
        ram_waddr       = wr_ptr_reg;
        ram_wdata       = ram_rdata;
        ram_re          = 1'b0;
        ram_raddr       = rd_ptr_reg;
        out_load        = 1'b0;
        load_word.status     = res_status_reg;
        load_word.boarded_id = '0;
        load_word.remaining  = occ_ext[REM_W-1:0];
        load_word.last       = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    id_next = visitor_id[STORE_W-1:0];
                    unique case (command)
                        CMD_REGISTER:
                        begin
                            if (occ_reg == CNT_W'(QUEUE_DEPTH))
                            begin
                                res_status_next = STAT_FULL;
                                state_next      = S_RESULT;
                            end
                            else
                            begin
                                occ_next        = occ_reg + 1'b1;
                                res_status_next = STAT_OK;
                                if (express)
                                begin
                                    fast_cnt_next = fast_cnt_reg + 1'b1;
                                end
                                if (express && (occ_reg != fast_cnt_reg))
                                begin
                                    rd_ptr_next  = ptr_dec(tail_ptr);
                                    wr_ptr_next  = tail_ptr;
                                    rd_left_next = occ_reg - fast_cnt_reg;
                                    pend_next    = 1'b0;
                                    insert_next  = 1'b1;
                                    state_next   = S_MOVE;
                                end
                                else
                                begin
                                    ram_we     = 1'b1;
                                    ram_waddr  = tail_ptr;
                                    ram_wdata  = visitor_id[STORE_W-1:0];
                                    state_next = S_RESULT;
                                end
                            end
                        end
                        CMD_CALL:
                        begin
                            if (occ_reg == '0)
                            begin
                                res_status_next = STAT_EMPTY;
                                state_next      = S_RESULT;
                            end
                            else
                            begin
                                occ_next      = occ_reg - pop_n;
                                fast_cnt_next = fast_cnt_reg - fast_pop;
                                pop_left_next = pop_n;
                                rd_ptr_next   = head_reg;
                                state_next    = S_POP_RD;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (occ_reg == '0)
                            begin
                                res_status_next = STAT_NOT_FOUND;
                                state_next      = S_RESULT;
                            end
                            else
                            begin
                                rd_ptr_next  = head_reg;
                                rd_left_next = occ_reg;
                                cmp_idx_next = '0;
                                pend_next    = 1'b0;
                                state_next   = S_SEARCH;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_MOVE:
            begin
                if (rd_left_reg != '0)
                begin
                    ram_re       = 1'b1;
                    rd_ptr_next  = insert_reg ? ptr_dec(rd_ptr_reg) : ptr_inc(rd_ptr_reg);
                    rd_left_next = rd_left_reg - 1'b1;
                    pend_next    = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    ram_we      = 1'b1;
                    wr_ptr_next = insert_reg ? ptr_dec(wr_ptr_reg) : ptr_inc(wr_ptr_reg);
                end
                else if (rd_left_reg == '0)
                begin
                    if (insert_reg)
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = id_reg;
                    end
                    res_status_next = STAT_OK;
                    state_next      = S_RESULT;
                end
            end
            S_SEARCH:
            begin
                if (rd_left_reg != '0)
                begin
                    ram_re       = 1'b1;
                    rd_ptr_next  = ptr_inc(rd_ptr_reg);
                    rd_left_next = rd_left_reg - 1'b1;
                    cmp_ptr_next = rd_ptr_reg;
                    pend_next    = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    cmp_idx_next = cmp_idx_reg + 1'b1;
                    if (ram_rdata == id_reg)
                    begin
                        wr_ptr_next  = cmp_ptr_reg;
                        rd_ptr_next  = ptr_inc(cmp_ptr_reg);
                        rd_left_next = occ_reg - 1'b1 - cmp_idx_reg;
                        pend_next    = 1'b0;
                        insert_next  = 1'b0;
                        occ_next     = occ_reg - 1'b1;
                        if (cmp_idx_reg < fast_cnt_reg)
                        begin
                            fast_cnt_next = fast_cnt_reg - 1'b1;
                        end
                        state_next = S_MOVE;
                    end
                    else if (cmp_idx_reg == occ_reg - 1'b1)
                    begin
                        res_status_next = STAT_NOT_FOUND;
                        state_next      = S_RESULT;
                    end
                end
            end
            S_POP_RD:
            begin
                ram_re      = 1'b1;
                rd_ptr_next = ptr_inc(rd_ptr_reg);
                state_next  = S_POP_WR;
            end
            S_POP_WR:
            begin
                load_word.status     = STAT_OK;
                load_word.boarded_id = rd_ext[ID_BITS-1:0];
                load_word.last       = (pop_left_reg == CNT_W'(1));
                if (out_free)
                begin
                    out_load      = 1'b1;
                    pop_left_next = pop_left_reg - 1'b1;
                    if (pop_left_reg == CNT_W'(1))
                    begin
                        head_next  = rd_ptr_reg;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_POP_RD;
                    end
                end
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            occ_reg      <= '0;
            fast_cnt_reg <= '0;
            head_reg     <= '0;
            rd_left_reg  <= '0;
            pop_left_reg <= '0;
            pend_reg     <= 1'b0;
            seats_reg    <= SEATS_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            occ_reg      <= occ_next;
            fast_cnt_reg <= fast_cnt_next;
            head_reg     <= head_next;
            rd_left_reg  <= rd_left_next;
            pop_left_reg <= pop_left_next;
            pend_reg     <= pend_next;
            if (cfg_wr_en)
            begin
                seats_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg     <= rd_ptr_next;
        wr_ptr_reg     <= wr_ptr_next;
        cmp_ptr_reg    <= cmp_ptr_next;
        cmp_idx_reg    <= cmp_idx_next;
        insert_reg     <= insert_next;
        id_reg         <= id_next;
        res_status_reg <= res_status_next;
    end

    tcpq_ram #(
        .DEPTH  (QUEUE_DEPTH),
        .WIDTH  (STORE_W),
        .ADDR_W (PTR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tcpq_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .load_word (load_word),
        .free      (out_free),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_word  (out_word)
    );

    assign status     = out_word.status;
    assign boarded_id = out_word.boarded_id;
    assign remaining  = out_word.remaining;
    assign last       = out_word.last;

`ifndef SYNTHESIS
    a_fast_within_occ: assert property (@(posedge clk) disable iff (!rst_n)
        fast_cnt_reg <= occ_reg)
        else $error("fast entry count exceeds occupancy");

    a_register_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (command == CMD_REGISTER)
            && (occ_reg != CNT_W'(QUEUE_DEPTH)))
        |=> (occ_reg == $past(occ_reg) + 1'b1))
        else $error("accepted register did not add one entry");

    a_call_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (command == CMD_CALL) && (occ_reg != '0))
        |=> (occ_reg < $past(occ_reg)))
        else $error("call on a nonempty queue did not pop");

    a_no_load_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_MOVE) || (state_reg == S_SEARCH)) |-> !out_load)
        else $error("result word loaded during a memory walk");
`endif

endmodule

### tb/two_class_priority_queue_batch_pop_unit_test.sv
// ----------------------------------------------------------------------------
// two_class_priority_queue_batch_pop_unit_test: self-checking queue bench
// Sends register, call and remove words with random gaps and output stalls.
// A behavioral copy of the two-class queue predicts every reply word. Each
// reply is compared field by field against the oldest prediction. The seat
// count is changed between phases, including its extreme settings.
// ----------------------------------------------------------------------------
module two_class_priority_queue_batch_pop_unit_test;
    import tcpq_pkg::*;

    localparam int LINE_DEPTH     = 16;
    localparam int SETTLE_CYCLES  = 48;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_WORDS    = 24;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [SEATS_W-1:0]  cfg_wr_data = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [CMD_W-1:0]    command = CMD_REGISTER;
    logic [ID_BITS-1:0]  visitor_id = '0;
    logic                express = 1'b0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [ID_BITS-1:0]  boarded_id;
    logic [REM_W-1:0]    remaining;
    logic                last;

    logic [ID_BITS-1:0]  line_ids[$];
    logic                line_fast[$];
    logic [SEATS_W-1:0]  seat_setting = SEATS_RESET;
    out_word_t           pending_replies[$];
    int unsigned         errors = 0;
    int unsigned         quiet_cycles = 0;
    int unsigned         sink_stall = 0;
    bit                  steady = 1'b0;

    two_class_priority_queue_batch_pop_unit #(
        .QUEUE_DEPTH(LINE_DEPTH),
        .ID_WIDTH(ID_BITS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .command(command),
        .visitor_id(visitor_id),
        .express(express),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .boarded_id(boarded_id),
        .remaining(remaining),
        .last(last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void apply_visitor_command(input logic [CMD_W-1:0] cmd,
                                                  input logic [ID_BITS-1:0] id,
                                                  input logic fast);
        out_word_t          w;
        int                 pos;
        int                 take;
        logic [ID_BITS-1:0] boarded[$];
        w = '0;
        w.last = 1'b1;
        case (cmd)
            CMD_REGISTER:
            begin
                if (line_ids.size() >= LINE_DEPTH)
                    w.status = STAT_FULL;
                else
                begin
                    pos = line_ids.size();
                    if (fast)
                    begin
                        for (int i = line_fast.size() - 1; i >= 0; i--)
                            if (!line_fast[i])
                                pos = i;
                    end
                    line_ids.insert(pos, id);
                    line_fast.insert(pos, fast);
                    w.status = STAT_OK;
                end
                w.remaining = REM_W'(line_ids.size());
                pending_replies.push_back(w);
            end
            CMD_CALL:
            begin
                if (line_ids.size() == 0)
                begin
                    w.status = STAT_EMPTY;
                    pending_replies.push_back(w);
                end
                else
                begin
                    take = (seat_setting == 0) ? 1 :
                           (seat_setting > MAX_BATCH) ? MAX_BATCH : int'(seat_setting);
                    if (take > line_ids.size())
                        take = line_ids.size();
                    repeat (take)
                    begin
                        boarded.push_back(line_ids.pop_front());
                        void'(line_fast.pop_front());
                    end
                    foreach (boarded[i])
                    begin
                        w.status = STAT_OK;
                        w.boarded_id = boarded[i];
                        w.remaining = REM_W'(line_ids.size());
                        w.last = (i == take - 1);
                        pending_replies.push_back(w);
                    end
                end
            end
            CMD_REMOVE:
            begin
                w.status = STAT_NOT_FOUND;
                pos = -1;
                for (int i = line_ids.size() - 1; i >= 0; i--)
                    if (line_ids[i] == id)
                        pos = i;
                if (pos >= 0)
                begin
                    line_ids.delete(pos);
                    line_fast.delete(pos);
                    w.status = STAT_OK;
                end
                w.remaining = REM_W'(line_ids.size());
                pending_replies.push_back(w);
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic check_reply();
        out_word_t want;
        if (pending_replies.size() == 0)
        begin
            $error("unexpected word: status %0d boarded_id %h remaining %0d last %0d",
                   status, boarded_id, remaining, last);
            errors++;
            return;
        end
        want = pending_replies.pop_front();
        if (status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, status);
            errors++;
        end
        if (boarded_id !== want.boarded_id)
        begin
            $error("boarded_id: expected %h, got %h", want.boarded_id, boarded_id);
            errors++;
        end
        if (remaining !== want.remaining)
        begin
            $error("remaining: expected %0d, got %0d", want.remaining, remaining);
            errors++;
        end
        if (last !== want.last)
        begin
            $error("last: expected %0d, got %0d", want.last, last);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (sink_stall != 0)
        begin
            sink_stall <= sink_stall - 1;
            out_ready <= 1'b0;
        end
        else if (!steady && $urandom_range(0, 9) == 0)
        begin
            sink_stall <= $urandom_range(0, 18);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (out_valid && out_ready)
                check_reply();
        end
    end

    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [ID_BITS-1:0] id,
                             input logic fast);
        if (!steady && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        visitor_id <= id;
        express <= fast;
        do
            @(posedge clk);
        while (!in_ready);
        apply_visitor_command(cmd, id, fast);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_boat_seats(input logic [SEATS_W-1:0] seats);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= seats;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        seat_setting = seats;
    endtask

    task automatic test_empty_queue();
        send_word(CMD_CALL, '0, 1'b0);
        send_word(CMD_REMOVE, 32'd5, 1'b0);
        send_word(CMD_UNUSED, '1, 1'b1);
    endtask

    task automatic test_class_order();
        send_word(CMD_REGISTER, 32'h0000_0000, 1'b0);
        send_word(CMD_REGISTER, 32'hFFFF_FFFF, 1'b1);
        send_word(CMD_REGISTER, 32'hA5A5_0001, 1'b1);
        send_word(CMD_REGISTER, 32'h5A5A_0002, 1'b0);
        send_word(CMD_REMOVE, 32'hA5A5_0001, 1'b0);
        send_word(CMD_REMOVE, 32'h1234_5678, 1'b0);
        send_word(CMD_CALL, '0, 1'b0);
    endtask

    task automatic test_full_queue();
        for (int i = 0; i < LINE_DEPTH; i++)
            send_word(CMD_REGISTER, 32'h0100_0000 + i, 1'($urandom_range(0, 1)));
        send_word(CMD_REGISTER, 32'hDEAD_0000, 1'b1);
        set_boat_seats(4'd15);
        send_word(CMD_CALL, '0, 1'b0);
        set_boat_seats(4'd0);
        send_word(CMD_CALL, '0, 1'b0);
    endtask

    task automatic random_phase(input int reg_pct);
        int                 pick;
        logic [ID_BITS-1:0] id;
        for (int n = 0; n < PHASE_WORDS; n++)
        begin
            pick = $urandom_range(0, 99);
            id = ($urandom_range(0, 3) == 0) ? ID_BITS'($urandom_range(0, 15))
                                             : ID_BITS'($urandom());
            if (pick < reg_pct)
                send_word(CMD_REGISTER, id, 1'($urandom_range(0, 1)));
            else if (pick < reg_pct + (95 - reg_pct) / 3)
                send_word(CMD_CALL, id, 1'($urandom_range(0, 1)));
            else if (pick < 95)
            begin
                if (line_ids.size() != 0 && $urandom_range(0, 3) != 0)
                    id = line_ids[$urandom_range(0, line_ids.size() - 1)];
                send_word(CMD_REMOVE, id, 1'($urandom_range(0, 1)));
            end
            else
                send_word(CMD_UNUSED, id, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_random_traffic();
        logic [SEATS_W-1:0] seats_plan[5];
        int                 fill_plan[5];
        seats_plan = '{4'd1, 4'd8, 4'd15, 4'd0, 4'd4};
        seats_plan[3] = SEATS_W'($urandom_range(0, 15));
        fill_plan = '{65, 40, 55, 60, 45};
        for (int p = 0; p < 5; p++)
        begin
            set_boat_seats(seats_plan[p]);
            steady = (p == 4);
            random_phase(fill_plan[p]);
        end
    endtask

    initial
    begin
        wait (rst_n);
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("two_class_priority_queue_batch_pop_unit_test: FAIL");
        $finish;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_queue();
        test_class_order();
        test_full_queue();
        test_random_traffic();
        settle();
        if (errors == 0)
            $display("two_class_priority_queue_batch_pop_unit_test: PASS");
        else
            $display("two_class_priority_queue_batch_pop_unit_test: FAIL");
        $finish;
    end

endmodule

### filelist.f
design/tcpq_pkg.sv
design/tcpq_ram.sv
design/tcpq_out_reg.sv
design/two_class_priority_queue_batch_pop_unit.sv
tb/two_class_priority_queue_batch_pop_unit_test.sv
